// ===== rtl/ukx_pkg.sv =====
// Shared types and constants for the unique key indexer.
package ukx_pkg;

   // Field widths of the request and response items.
   localparam int KEY_W         = 64;
   localparam int GROUP_INDEX_W = 10;
   localparam int COUNT_OUT_W   = 32;
   localparam int POSITION_W    = 32;

   // Multiplicative hash constant (golden ratio of 2^64).
   localparam logic [63:0] HASH_MULT = 64'h9E3779B97F4A7C15;

   // Width of the set tag kept with each table entry.
   localparam int EPOCH_W = 8;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic             clear;
   } req_payload_type;

   typedef struct packed {
      logic [GROUP_INDEX_W-1:0] group_index;
      logic                     is_new;
      logic [COUNT_OUT_W-1:0]   count_so_far;
      logic [POSITION_W-1:0]    position;
      logic                     table_full;
   } rsp_payload_type;

   // Operations of the shared multiplier.
   typedef enum logic [2:0] {
      MUL_KEY_LO_LO,
      MUL_KEY_HI_LO,
      MUL_KEY_LO_HI,
      MUL_QUOTIENT,
      MUL_REMAINDER
   } mul_op_type;

   // Outcome of a table lookup.
   typedef enum logic [1:0] {
      RES_HIT,
      RES_NEW,
      RES_FULL
   } result_kind_type;

   typedef enum logic [3:0] {
      ST_INIT_SWEEP,
      ST_IDLE,
      ST_CLEAR_SWEEP,
      ST_HASH_LL,
      ST_HASH_HL,
      ST_HASH_LH,
      ST_HASH_QUOT,
      ST_HASH_REM,
      ST_HASH_REDUCE,
      ST_PROBE_READ,
      ST_PROBE_CMP,
      ST_RESPOND
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic            accept;
      logic            sweep_write;
      logic            mul_en;
      mul_op_type      mul_op;
      logic            reduce;
      logic            probe_read;
      logic            probe_next;
      logic            write_new;
      logic            write_inc;
      logic            result_load;
      result_kind_type result_kind;
      logic            rsp_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_sweep;
      logic sweep_last;
      logic probe_hit;
      logic probe_empty;
      logic probe_last;
      logic can_insert;
      logic rsp_free;
   } status_type;

endpackage

// ===== rtl/ukx_if.sv =====
// Valid/ready channel interfaces for requests and responses.
interface ukx_req_if import ukx_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface ukx_rsp_if import ukx_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/unique_key_indexer_unit.sv =====
// A response is loaded once the hash, the home slot and every table probe are done; it waits
// while the output register is busy. The next request is taken in the cycle after the response
// is loaded. Work is paced by five passes through one shared 32x32 multiplier for the hash and
// slot, and by the single read port of the table memory, with a read and a compare per probe.
// Reset starts a sweep of all TABLE_ENTRIES table tags with ready low; every 255th clear
// request repeats that sweep before its key is handled.
module unique_key_indexer_unit import ukx_pkg::*; #(
   parameter int TABLE_ENTRIES = 1024,
   parameter int COUNT_BITS    = 32
) (
   input  logic       clock,
   input  logic       reset,
   ukx_req_if.sink    req_if,
   ukx_rsp_if.source  rsp_if
);

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   ukx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Table, hash and counters.
   ukx_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .COUNT_BITS    (COUNT_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_if.payload),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .rsp_payload (rsp_if.payload),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

// ===== rtl/ukx_ctrl.sv =====
// Controller state machine that sequences hashing, probing and responses.
module ukx_ctrl import ukx_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // State register; reset starts the table initialization sweep.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT_SWEEP: begin
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = status.need_sweep ? ST_CLEAR_SWEEP : ST_HASH_LL;
            end
         end
         ST_CLEAR_SWEEP: begin
            if (status.sweep_last) state_in = ST_HASH_LL;
         end
         ST_HASH_LL:     state_in = ST_HASH_HL;
         ST_HASH_HL:     state_in = ST_HASH_LH;
         ST_HASH_LH:     state_in = ST_HASH_QUOT;
         ST_HASH_QUOT:   state_in = ST_HASH_REM;
         ST_HASH_REM:    state_in = ST_HASH_REDUCE;
         ST_HASH_REDUCE: state_in = ST_PROBE_READ;
         ST_PROBE_READ:  state_in = ST_PROBE_CMP;
         ST_PROBE_CMP: begin
            if (status.probe_hit || status.probe_empty || status.probe_last) begin
               state_in = ST_RESPOND;
            end else begin
               state_in = ST_PROBE_READ;
            end
         end
         ST_RESPOND: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd             = '0;
      cmd.mul_op      = MUL_KEY_LO_LO;
      cmd.result_kind = RES_FULL;
      req_ready       = 1'b0;
      unique case (state_ff)
         ST_INIT_SWEEP: begin
            cmd.sweep_write = 1'b1;
         end
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_CLEAR_SWEEP: begin
            cmd.sweep_write = 1'b1;
         end
         ST_HASH_LL: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MUL_KEY_LO_LO;
         end
         ST_HASH_HL: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MUL_KEY_HI_LO;
         end
         ST_HASH_LH: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MUL_KEY_LO_HI;
         end
         ST_HASH_QUOT: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MUL_QUOTIENT;
         end
         ST_HASH_REM: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MUL_REMAINDER;
         end
         ST_HASH_REDUCE: begin
            cmd.reduce = 1'b1;
         end
         ST_PROBE_READ: begin
            cmd.probe_read = 1'b1;
         end
         ST_PROBE_CMP: begin
            if (status.probe_hit) begin
               cmd.write_inc   = 1'b1;
               cmd.result_load = 1'b1;
               cmd.result_kind = RES_HIT;
            end else if (status.probe_empty && status.can_insert) begin
               cmd.write_new   = 1'b1;
               cmd.result_load = 1'b1;
               cmd.result_kind = RES_NEW;
            end else if (status.probe_empty || status.probe_last) begin
               cmd.result_load = 1'b1;
               cmd.result_kind = RES_FULL;
            end else begin
               cmd.probe_next = 1'b1;
            end
         end
         ST_RESPOND: begin
            cmd.rsp_load = status.rsp_free;
         end
         default: begin
            cmd.accept = 1'b0;
         end
      endcase
   end

   // A response is never loaded over one that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> status.rsp_free)
      else $error("response loaded while output register busy");

   // Every table read is followed by its compare.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PROBE_READ |=> state_ff == ST_PROBE_CMP)
      else $error("probe read not followed by compare");

   // Only one request is in work at a time.
   assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> !req_ready)
      else $error("ready held after a request was accepted");

endmodule

// ===== rtl/ukx_dp.sv =====
// Datapath: hash arithmetic, the key table memory, counters and response register.
module ukx_dp import ukx_pkg::*; #(
   parameter int TABLE_ENTRIES = 1024,
   parameter int COUNT_BITS    = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  cmd_type         cmd,
   output status_type      status
);

   localparam int IDX_W   = $clog2(TABLE_ENTRIES);
   localparam int NGRP_W  = $clog2(TABLE_ENTRIES + 1);
   localparam int REM_W   = IDX_W + 1;
   localparam logic [31:0] RECIP = 32'((64'd1 << 32) / TABLE_ENTRIES);
   localparam logic [31:0] N_WORD = 32'(TABLE_ENTRIES);
   localparam logic [REM_W-1:0] N_REM = REM_W'(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [NGRP_W-1:0] N_GRP = NGRP_W'(TABLE_ENTRIES);

   // Table memory: set tag, key, group and count per entry.
   logic [EPOCH_W-1:0]    tag_mem   [TABLE_ENTRIES];
   logic [KEY_W-1:0]      key_mem   [TABLE_ENTRIES];
   logic [IDX_W-1:0]      group_mem [TABLE_ENTRIES];
   logic [COUNT_BITS-1:0] count_mem [TABLE_ENTRIES];

   // Control state.
   logic [EPOCH_W-1:0]    epoch_ff;
   logic [IDX_W-1:0]      sweep_addr_ff;
   logic [NGRP_W-1:0]     next_group_ff;
   logic [POSITION_W-1:0] item_cnt_ff;
   logic                  rsp_valid_ff;

   // Payload registers.
   logic [KEY_W-1:0]      key_ff;
   logic [POSITION_W-1:0] pos_ff;
   logic [31:0]           hash_ff;
   logic [31:0]           quot_ff;
   logic [REM_W-1:0]      rem_ff;
   logic [IDX_W-1:0]      slot_ff;
   logic [IDX_W-1:0]      probe_cnt_ff;
   logic [EPOCH_W-1:0]    rd_tag_ff;
   logic [KEY_W-1:0]      rd_key_ff;
   logic [IDX_W-1:0]      rd_group_ff;
   logic [COUNT_BITS-1:0] rd_count_ff;
   logic [IDX_W-1:0]      pend_group_ff;
   logic                  pend_new_ff;
   logic [COUNT_BITS-1:0] pend_count_ff;
   logic                  pend_full_ff;
   rsp_payload_type       rsp_payload_ff;

   logic [31:0]           mul_a;
   logic [31:0]           mul_b;
   logic [63:0]           prod;
   logic [COUNT_BITS-1:0] inc_count;
   logic [COUNT_OUT_W-1:0] count_out;

   // Control state: set tag, sweep pointer, group and item counters, output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff      <= EPOCH_W'(1);
         sweep_addr_ff <= '0;
         next_group_ff <= '0;
         item_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.sweep_write) begin
            sweep_addr_ff <= (sweep_addr_ff == LAST_IDX) ? '0 : sweep_addr_ff + 1'b1;
         end
         if (cmd.accept) begin
            if (req_payload.clear) begin
               next_group_ff <= '0;
               item_cnt_ff   <= POSITION_W'(1);
               epoch_ff      <= (epoch_ff == '1) ? EPOCH_W'(1) : epoch_ff + 1'b1;
            end else begin
               item_cnt_ff <= item_cnt_ff + 1'b1;
            end
         end else if (cmd.write_new) begin
            next_group_ff <= next_group_ff + 1'b1;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         key_ff <= req_payload.key;
         pos_ff <= req_payload.clear ? '0 : item_cnt_ff;
      end
   end

   // Shared 32x32 multiplier operand selection.
   always_comb begin
      mul_a = key_ff[31:0];
      mul_b = HASH_MULT[31:0];
      unique case (cmd.mul_op)
         MUL_KEY_LO_LO: begin
            mul_a = key_ff[31:0];
            mul_b = HASH_MULT[31:0];
         end
         MUL_KEY_HI_LO: begin
            mul_a = key_ff[63:32];
            mul_b = HASH_MULT[31:0];
         end
         MUL_KEY_LO_HI: begin
            mul_a = key_ff[31:0];
            mul_b = HASH_MULT[63:32];
         end
         MUL_QUOTIENT: begin
            mul_a = hash_ff;
            mul_b = RECIP;
         end
         MUL_REMAINDER: begin
            mul_a = quot_ff;
            mul_b = N_WORD;
         end
         default: begin
            mul_a = key_ff[31:0];
            mul_b = HASH_MULT[31:0];
         end
      endcase
   end

   assign prod = {32'd0, mul_a} * {32'd0, mul_b};

   // Hash bits 63:32 of key*constant, then the home slot modulo the table size.
   // The reciprocal estimate of the quotient is low by at most one, so one
   // compare and subtract finishes the remainder.
   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         unique case (cmd.mul_op)
            MUL_KEY_LO_LO: hash_ff <= prod[63:32];
            MUL_KEY_HI_LO: hash_ff <= hash_ff + prod[31:0];
            MUL_KEY_LO_HI: hash_ff <= hash_ff + prod[31:0];
            MUL_QUOTIENT:  quot_ff <= prod[63:32];
            MUL_REMAINDER: rem_ff  <= REM_W'(hash_ff - prod[31:0]);
            default:       hash_ff <= hash_ff;
         endcase
      end
   end

   // Probe pointer: home slot, then linear probing with wrap.
   always_ff @(posedge clock) begin
      if (cmd.reduce) begin
         slot_ff      <= (rem_ff >= N_REM) ? IDX_W'(rem_ff - N_REM) : IDX_W'(rem_ff);
         probe_cnt_ff <= '0;
      end else if (cmd.probe_next) begin
         slot_ff      <= (slot_ff == LAST_IDX) ? '0 : slot_ff + 1'b1;
         probe_cnt_ff <= probe_cnt_ff + 1'b1;
      end
   end

   // Table read port.
   always_ff @(posedge clock) begin
      if (cmd.probe_read) begin
         rd_tag_ff   <= tag_mem[slot_ff];
         rd_key_ff   <= key_mem[slot_ff];
         rd_group_ff <= group_mem[slot_ff];
         rd_count_ff <= count_mem[slot_ff];
      end
   end

   // Table write ports. A sweep marks every entry as belonging to no set.
   always_ff @(posedge clock) begin
      if (cmd.sweep_write) begin
         tag_mem[sweep_addr_ff] <= '0;
      end else if (cmd.write_new) begin
         tag_mem[slot_ff] <= epoch_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_new) begin
         key_mem[slot_ff]   <= key_ff;
         group_mem[slot_ff] <= IDX_W'(next_group_ff);
      end
   end

   assign inc_count = (rd_count_ff == '1) ? rd_count_ff : rd_count_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.write_new) begin
         count_mem[slot_ff] <= COUNT_BITS'(1);
      end else if (cmd.write_inc) begin
         count_mem[slot_ff] <= inc_count;
      end
   end

   // Pending result of the lookup.
   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         case (cmd.result_kind)
            RES_HIT: begin
               pend_group_ff <= rd_group_ff;
               pend_new_ff   <= 1'b0;
               pend_count_ff <= inc_count;
               pend_full_ff  <= 1'b0;
            end
            RES_NEW: begin
               pend_group_ff <= IDX_W'(next_group_ff);
               pend_new_ff   <= 1'b1;
               pend_count_ff <= COUNT_BITS'(1);
               pend_full_ff  <= 1'b0;
            end
            default: begin
               pend_group_ff <= '0;
               pend_new_ff   <= 1'b0;
               pend_count_ff <= '0;
               pend_full_ff  <= 1'b1;
            end
         endcase
      end
   end

   // Count narrowed to the output width, saturating when the count is wider.
   generate
      if (COUNT_BITS > COUNT_OUT_W) begin : g_count_sat
         assign count_out = (|pend_count_ff[COUNT_BITS-1:COUNT_OUT_W]) ? '1
                            : pend_count_ff[COUNT_OUT_W-1:0];
      end else begin : g_count_ext
         assign count_out = COUNT_OUT_W'(pend_count_ff);
      end
   endgenerate

   // Output register.
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_payload_ff.group_index  <= GROUP_INDEX_W'(pend_group_ff);
         rsp_payload_ff.is_new       <= pend_new_ff;
         rsp_payload_ff.count_so_far <= count_out;
         rsp_payload_ff.position     <= pos_ff;
         rsp_payload_ff.table_full   <= pend_full_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Status to the controller.
   always_comb begin
      status.need_sweep  = req_payload.clear && (epoch_ff == '1);
      status.sweep_last  = (sweep_addr_ff == LAST_IDX);
      status.probe_empty = (rd_tag_ff != epoch_ff);
      status.probe_hit   = (rd_tag_ff == epoch_ff) && (rd_key_ff == key_ff);
      status.probe_last  = (probe_cnt_ff == LAST_IDX);
      status.can_insert  = (next_group_ff < N_GRP);
      status.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   // A new entry is only placed while groups remain.
   assert property (@(posedge clock) disable iff (reset)
      cmd.write_new |-> (next_group_ff < N_GRP))
      else $error("entry inserted with no group left");

   // The group counter never passes the table size.
   assert property (@(posedge clock) disable iff (reset)
      next_group_ff <= N_GRP)
      else $error("group counter beyond table size");

   // A count update only lands on an entry of the current set holding the key.
   assert property (@(posedge clock) disable iff (reset)
      cmd.write_inc |-> (rd_tag_ff == epoch_ff && rd_key_ff == key_ff))
      else $error("count update on a non-matching entry");

endmodule
